>>> rtl/capability_entry_lookup_defines.svh
// Assertion macros for the capability entry lookup checker.
// No dependencies; include with the bare file name.
`ifndef CAPABILITY_ENTRY_LOOKUP_DEFINES_SVH
`define CAPABILITY_ENTRY_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CEL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("capability lookup check failed");

// Next-cycle implication, disabled while reset is low.
`define CEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("capability lookup check failed");

`endif

>>> rtl/cel_pkg.sv
// Types, constants and helper functions for the capability entry lookup.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cel_pkg;

    localparam int RES_MAX  = 3;  // most results one byte can cause
    localparam int RQ_DEPTH = 4;  // result queue entries
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    // Query kinds as written to the query_kind register.
    localparam logic [1:0] QK_NUM   = 2'd0;
    localparam logic [1:0] QK_FLAG  = 2'd1;
    localparam logic [1:0] QK_STR   = 2'd2;
    localparam logic [1:0] QK_NEVER = 2'd3;  // undefined kind, never matches

    // Configuration register indexes.
    localparam logic CFG_CAP_NAME   = 1'b0;
    localparam logic CFG_QUERY_KIND = 1'b1;

    // Characters of the entry syntax.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [3:0] {
        PH_SEEK,
        PH_WS,
        PH_NAME2,
        PH_SEP,
        PH_NUM_WS,
        PH_NUM_DIG,
        PH_STR,
        PH_CARET,
        PH_ESC,
        PH_OCT
    } t_phase;

    typedef enum logic [2:0] {
        K_SBYTE = 3'd0,
        K_SEND  = 3'd1,
        K_FLAG  = 3'd2,
        K_NUM   = 3'd3,
        K_NONE  = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] entry_byte;
        logic       entry_end;
    } t_in_item;

    typedef struct packed {
        t_kind              result_kind;
        logic [7:0]         string_byte;
        logic signed [31:0] number_value;
        logic               final_result;
    } t_out_item;

    typedef struct packed {
        logic [15:0] cap_name;
        logic [1:0]  query_kind;
    } t_cfg;

    // Results caused by one accepted byte.
    typedef struct packed {
        logic [1:0]                n;
        t_out_item [RES_MAX-1:0]   e;
    } t_res_list;

    function automatic logic is_ws(input logic [7:0] b);
        return (b inside {8'h20, [8'h09:8'h0D]});
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b inside {[8'h30:8'h39]});
    endfunction

    // Field-separator check on a byte that broke a match.
    function automatic t_phase sep_phase(input logic [7:0] b);
        return (b == CH_COLON) ? PH_WS : PH_SEEK;
    endfunction

    // accum * 10 + digit, clamped at 2^31.
    function automatic logic [31:0] mul10_add(input logic [31:0] acc, input logic [7:0] b);
        logic [35:0] m;
        m = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, b[3:0]};
        return (m > 36'h080000000) ? 32'h8000_0000 : m[31:0];
    endfunction

    function automatic logic [31:0] num_value(input logic [31:0] acc, input logic neg);
        if (neg) return 32'd0 - acc;
        return (acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc;
    endfunction

    // Decoded byte after a backslash (octal leaders handled elsewhere).
    function automatic logic [7:0] esc_byte(input logic [7:0] b);
        case (b)
            8'h45:   return CH_ESC;  // E
            8'h6E:   return 8'h0A;   // n
            8'h72:   return 8'h0D;   // r
            8'h74:   return 8'h09;   // t
            8'h62:   return 8'h08;   // b
            8'h66:   return 8'h0C;   // f
            default: return b;
        endcase
    endfunction

    function automatic t_res_list push(input t_res_list l, input t_kind k,
                                       input logic [7:0] sb, input logic [31:0] nv,
                                       input logic fin);
        t_res_list r;
        t_out_item it;
        r = l;
        it.result_kind  = k;
        it.string_byte  = sb;
        it.number_value = nv;
        it.final_result = fin;
        case (l.n)
            2'd0:    r.e[0] = it;
            2'd1:    r.e[1] = it;
            2'd2:    r.e[2] = it;
            default: ;
        endcase
        if (l.n != 2'd3) r.n = l.n + 2'd1;
        return r;
    endfunction

    // Close out an unfinished query at the end of the entry text.
    function automatic t_res_list end_text(input t_res_list l, input t_phase ph,
                                           input logic done, input logic [31:0] acc,
                                           input logic neg, input logic [7:0] oct);
        t_res_list r;
        r = l;
        if (!done) begin
            case (ph)
                PH_NUM_WS, PH_NUM_DIG: begin
                    r = push(r, K_NUM, 8'd0, num_value(acc, neg), 1'b1);
                end
                PH_OCT: begin
                    r = push(r, K_SBYTE, oct, 32'd0, 1'b0);
                    r = push(r, K_SEND, 8'd0, 32'd0, 1'b1);
                end
                PH_STR, PH_CARET, PH_ESC: begin
                    r = push(r, K_SEND, 8'd0, 32'd0, 1'b1);
                end
                default: begin
                    r = push(r, K_NONE, 8'd0, 32'd0, 1'b1);
                end
            endcase
        end
        return r;
    endfunction

endpackage

>>> rtl/cel_scanner.sv
// Per-byte scan state and result generation for the capability lookup.
// Depends on cel_pkg.
`timescale 1ns / 1ps

module cel_scanner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  cel_pkg::t_in_item  i_item,
    input  cel_pkg::t_cfg      i_cfg,
    output cel_pkg::t_res_list o_results
);
    import cel_pkg::*;

    t_phase      r_phase, n_phase, m_phase;
    logic [7:0]  r_oct, n_oct, m_oct;
    logic [1:0]  r_odig, n_odig, m_odig;
    logic [31:0] r_acc, n_acc, m_acc;
    logic        r_neg, n_neg, m_neg;
    logic        r_done, n_done, m_done;

    logic [7:0]  b;
    logic        name2_hit;
    logic [7:0]  oct_step;
    logic [1:0]  odig_step;

    assign b         = i_item.entry_byte;
    assign name2_hit = (b == i_cfg.cap_name[7:0]) && (i_cfg.query_kind != QK_NEVER);
    assign oct_step  = {r_oct[4:0], 3'b000} + {4'd0, b[3:0]};
    assign odig_step = r_odig + 2'd1;

    // Next state: m_* is the state after the byte, before end-of-entry.
    always_comb begin
        m_phase = r_phase;
        m_oct   = r_oct;
        m_odig  = r_odig;
        m_acc   = r_acc;
        m_neg   = r_neg;
        m_done  = r_done;
        if (!r_done) begin
            if (b == CH_NUL) begin
                m_done = 1'b1;
            end else begin
                case (r_phase)
                    PH_SEEK: begin
                        if (b == CH_COLON) m_phase = PH_WS;
                    end
                    PH_WS: begin
                        if (!is_ws(b)) begin
                            if (b == i_cfg.cap_name[15:8]) m_phase = PH_NAME2;
                            else m_phase = sep_phase(b);
                        end
                    end
                    PH_NAME2: begin
                        if (name2_hit) begin
                            if (i_cfg.query_kind == QK_FLAG) m_done = 1'b1;
                            else m_phase = PH_SEP;
                        end else begin
                            m_phase = sep_phase(b);
                        end
                    end
                    PH_SEP: begin
                        if (i_cfg.query_kind == QK_NUM && b == CH_HASH) begin
                            m_acc   = 32'd0;
                            m_neg   = 1'b0;
                            m_phase = PH_NUM_WS;
                        end else if (i_cfg.query_kind == QK_STR && b == CH_EQ) begin
                            m_phase = PH_STR;
                        end else begin
                            m_phase = sep_phase(b);
                        end
                    end
                    PH_NUM_WS: begin
                        if (!is_ws(b)) begin
                            if (b == CH_PLUS || b == CH_MINUS) begin
                                m_neg   = (b == CH_MINUS);
                                m_phase = PH_NUM_DIG;
                            end else if (is_digit(b)) begin
                                m_acc   = mul10_add(r_acc, b);
                                m_phase = PH_NUM_DIG;
                            end else begin
                                m_done = 1'b1;
                            end
                        end
                    end
                    PH_NUM_DIG: begin
                        if (is_digit(b)) m_acc = mul10_add(r_acc, b);
                        else m_done = 1'b1;
                    end
                    PH_STR: begin
                        if (b == CH_COLON) m_done = 1'b1;
                        else if (b == CH_CARET) m_phase = PH_CARET;
                        else if (b == CH_BSL) m_phase = PH_ESC;
                    end
                    PH_CARET: begin
                        m_phase = PH_STR;
                    end
                    PH_ESC: begin
                        if (b inside {[8'h30:8'h33]}) begin
                            m_oct   = {6'd0, b[1:0]};
                            m_odig  = 2'd1;
                            m_phase = PH_OCT;
                        end else begin
                            m_phase = PH_STR;
                        end
                    end
                    PH_OCT: begin
                        if (is_digit(b)) begin
                            m_oct  = oct_step;
                            m_odig = odig_step;
                            if (odig_step == 2'd3) m_phase = PH_STR;
                        end else begin
                            // Octal byte ends; the breaking byte is string text.
                            m_phase = PH_STR;
                            if (b == CH_COLON) m_done = 1'b1;
                            else if (b == CH_CARET) m_phase = PH_CARET;
                            else if (b == CH_BSL) m_phase = PH_ESC;
                        end
                    end
                    default: begin
                        m_phase = PH_SEEK;
                    end
                endcase
            end
        end

        if (i_item.entry_end) begin
            n_phase = PH_SEEK;
            n_oct   = 8'd0;
            n_odig  = 2'd0;
            n_acc   = 32'd0;
            n_neg   = 1'b0;
            n_done  = 1'b0;
        end else begin
            n_phase = m_phase;
            n_oct   = m_oct;
            n_odig  = m_odig;
            n_acc   = m_acc;
            n_neg   = m_neg;
            n_done  = m_done;
        end
    end

    // Results caused by the byte.
    always_comb begin
        o_results = '0;
        if (!r_done) begin
            if (b == CH_NUL) begin
                o_results = end_text(o_results, r_phase, r_done, r_acc, r_neg, r_oct);
            end else begin
                case (r_phase)
                    PH_NAME2: begin
                        if (name2_hit && i_cfg.query_kind == QK_FLAG)
                            o_results = push(o_results, K_FLAG, 8'd0, 32'd0, 1'b1);
                    end
                    PH_NUM_WS: begin
                        if (!is_ws(b) && b != CH_PLUS && b != CH_MINUS && !is_digit(b))
                            o_results = push(o_results, K_NUM, 8'd0,
                                             num_value(r_acc, r_neg), 1'b1);
                    end
                    PH_NUM_DIG: begin
                        if (!is_digit(b))
                            o_results = push(o_results, K_NUM, 8'd0,
                                             num_value(r_acc, r_neg), 1'b1);
                    end
                    PH_STR: begin
                        if (b == CH_COLON)
                            o_results = push(o_results, K_SEND, 8'd0, 32'd0, 1'b1);
                        else if (b != CH_CARET && b != CH_BSL)
                            o_results = push(o_results, K_SBYTE, b, 32'd0, 1'b0);
                    end
                    PH_CARET: begin
                        o_results = push(o_results, K_SBYTE, b - CH_AT, 32'd0, 1'b0);
                    end
                    PH_ESC: begin
                        if (!(b inside {[8'h30:8'h33]}))
                            o_results = push(o_results, K_SBYTE, esc_byte(b), 32'd0, 1'b0);
                    end
                    PH_OCT: begin
                        if (is_digit(b)) begin
                            if (odig_step == 2'd3)
                                o_results = push(o_results, K_SBYTE, oct_step, 32'd0, 1'b0);
                        end else begin
                            o_results = push(o_results, K_SBYTE, r_oct, 32'd0, 1'b0);
                            if (b == CH_COLON)
                                o_results = push(o_results, K_SEND, 8'd0, 32'd0, 1'b1);
                            else if (b != CH_CARET && b != CH_BSL)
                                o_results = push(o_results, K_SBYTE, b, 32'd0, 1'b0);
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (i_item.entry_end)
            o_results = end_text(o_results, m_phase, m_done, m_acc, m_neg, m_oct);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_oct   <= 8'd0;
            r_odig  <= 2'd0;
            r_acc   <= 32'd0;
            r_neg   <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_oct   <= n_oct;
            r_odig  <= n_odig;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_done  <= n_done;
        end
    end

endmodule

>>> rtl/capability_entry_lookup.sv
// Top level of the capability entry lookup: config registers, scanner, result queue.
// Depends on cel_pkg and cel_scanner.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_stall  i_in_data  (entry_byte, entry_end)
// out       output     o_out_valid/i_out_stall o_out_data (kind, byte, number, final)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One entry byte per cycle unless input stalls. Each byte updates the scan state
// in the same cycle it is taken and writes up to three results into a four-entry
// result queue; results leave one per cycle unless output stalls. Input stalls
// while fewer than three queue entries are free, as when bytes give more than one
// result or output stalls. Synchronous active-low reset clears the scan state, the
// queue and the registers (name 0, number query). Config writes are always ready.

module capability_entry_lookup (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cel_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cel_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import cel_pkg::*;

    // Configuration registers.
    t_cfg r_cfg;

    // Result queue.
    t_out_item           r_q [RQ_DEPTH];
    logic [RQ_AW-1:0]    r_wr_ptr;
    logic [RQ_AW-1:0]    r_rd_ptr;
    logic [RQ_AW:0]      r_count;

    logic      in_accept;
    logic      out_pop;
    logic      cfg_write;
    t_res_list results;
    logic [1:0] push_n;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Hold input off while a worst-case byte would not fit.
    assign o_in_stall  = (r_count > (RQ_AW+1)'(RQ_DEPTH - RES_MAX));
    assign in_accept   = i_in_valid && !o_in_stall;

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_q[r_rd_ptr];
    assign out_pop     = o_out_valid && !i_out_stall;

    assign push_n      = in_accept ? results.n : 2'd0;

    cel_scanner u_scanner (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_item    (i_in_data),
        .i_cfg     (r_cfg),
        .o_results (results)
    );

    // Register writes take effect for the next accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_write) begin
            case (i_cfg_index)
                CFG_CAP_NAME:   r_cfg.cap_name   <= i_cfg_data;
                CFG_QUERY_KIND: r_cfg.query_kind <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Queue storage: write this byte's results in order at the tail.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_MAX; k++) begin
            if (2'(k) < push_n) r_q[r_wr_ptr + RQ_AW'(k)] <= results.e[k];
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RQ_AW'(push_n);
            if (out_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count  <= r_count + (RQ_AW+1)'(push_n) - (RQ_AW+1)'(out_pop);
        end
    end

endmodule

>>> rtl/cel_checker.sv
// Port-level checks for the capability entry lookup, bound to the top level.
// Depends on cel_pkg and capability_entry_lookup_defines.svh.
`timescale 1ns / 1ps
`include "capability_entry_lookup_defines.svh"

module cel_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cel_pkg::t_out_item o_out_data
);

    // A stalled result holds until taken.
    `CEL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // With no result pending the input side is open.
    `CEL_ASSERT_NOW(a_empty_open, i_clk, i_rst_n, !o_out_valid, !o_in_stall)

    // Input stall only clears after a result has been taken.
    `CEL_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_in_stall && !(o_out_valid && !i_out_stall), o_in_stall)

endmodule

bind capability_entry_lookup cel_checker u_cel_checker (.*);

>>> tb/capability_lookup_checker.sv
// Checker for the capability entry lookup: watches the entry, result and register channels.
// Keeps its own copy of the lookup state, predicts results and compares them in order.
// Depends on cel_pkg for the channel structs and codes.
`timescale 1ns / 1ps

module capability_lookup_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  cel_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  cel_pkg::t_out_item i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import cel_pkg::*;

    // Lookup settings and scan state as the block should hold them.
    logic [15:0] want_name;
    logic [1:0]  want_kind;
    t_phase      scan_ph;
    logic [7:0]  oct_acc;
    logic [1:0]  oct_count;
    logic [31:0] num_mag;
    logic        num_neg;
    logic        answered;

    t_out_item   expected_results[$];
    int          step_results;
    int          errors = 0;

    function automatic logic is_blank(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_decimal(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    // One byte never causes more than RES_MAX results; drop any beyond that.
    task automatic put_result(input t_kind k, input logic [7:0] sb, input logic [31:0] nv,
                              input logic fin);
        t_out_item r;
        if (step_results < RES_MAX) begin
            r.result_kind  = k;
            r.string_byte  = sb;
            r.number_value = nv;
            r.final_result = fin;
            expected_results.push_back(r);
            step_results++;
        end
    endtask

    task automatic close_query(input t_kind k, input logic [31:0] nv);
        put_result(k, 8'd0, nv, 1'b1);
        answered = 1'b1;
    endtask

    task automatic report_number();
        logic [31:0] v;
        if (num_neg) v = 32'd0 - num_mag;
        else v = (num_mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : num_mag;
        close_query(K_NUM, v);
    endtask

    // A byte that breaks a match may itself open the next field.
    task automatic rescan(input logic [7:0] b);
        scan_ph = (b == CH_COLON) ? PH_WS : PH_SEEK;
    endtask

    task automatic string_char(input logic [7:0] b);
        if (b == CH_COLON) close_query(K_SEND, 32'd0);
        else if (b == CH_CARET) scan_ph = PH_CARET;
        else if (b == CH_BSL) scan_ph = PH_ESC;
        else put_result(K_SBYTE, b, 32'd0, 1'b0);
    endtask

    task automatic advance_scan(input logic [7:0] b);
        logic [63:0] prod;
        case (scan_ph)
            PH_SEEK: begin
                if (b == CH_COLON) scan_ph = PH_WS;
            end
            PH_WS: begin
                if (!is_blank(b)) begin
                    if (b == want_name[15:8]) scan_ph = PH_NAME2;
                    else rescan(b);
                end
            end
            PH_NAME2: begin
                if (b == want_name[7:0] && want_kind inside {QK_NUM, QK_FLAG, QK_STR}) begin
                    if (want_kind == QK_FLAG) close_query(K_FLAG, 32'd0);
                    else scan_ph = PH_SEP;
                end else begin
                    rescan(b);
                end
            end
            PH_SEP: begin
                if (want_kind == QK_NUM && b == CH_HASH) begin
                    num_mag = 32'd0;
                    num_neg = 1'b0;
                    scan_ph = PH_NUM_WS;
                end else if (want_kind == QK_STR && b == CH_EQ) begin
                    scan_ph = PH_STR;
                end else begin
                    rescan(b);
                end
            end
            PH_NUM_WS, PH_NUM_DIG: begin
                if (scan_ph == PH_NUM_WS && (b == CH_PLUS || b == CH_MINUS)) begin
                    num_neg = (b == CH_MINUS);
                    scan_ph = PH_NUM_DIG;
                end else if (is_decimal(b)) begin
                    prod = {32'd0, num_mag} * 64'd10 + {56'd0, b - 8'h30};
                    num_mag = (prod > 64'h8000_0000) ? 32'h8000_0000 : prod[31:0];
                    scan_ph = PH_NUM_DIG;
                end else if (!(scan_ph == PH_NUM_WS && is_blank(b))) begin
                    report_number();
                end
            end
            PH_STR: string_char(b);
            PH_CARET: begin
                put_result(K_SBYTE, b - CH_AT, 32'd0, 1'b0);
                scan_ph = PH_STR;
            end
            PH_ESC: begin
                scan_ph = PH_STR;
                case (b)
                    8'h45: put_result(K_SBYTE, CH_ESC, 32'd0, 1'b0);  // E
                    8'h6E: put_result(K_SBYTE, 8'h0A, 32'd0, 1'b0);   // n
                    8'h72: put_result(K_SBYTE, 8'h0D, 32'd0, 1'b0);   // r
                    8'h74: put_result(K_SBYTE, 8'h09, 32'd0, 1'b0);   // t
                    8'h62: put_result(K_SBYTE, 8'h08, 32'd0, 1'b0);   // b
                    8'h66: put_result(K_SBYTE, 8'h0C, 32'd0, 1'b0);   // f
                    default: begin
                        if (b >= 8'h30 && b <= 8'h33) begin
                            oct_acc   = b - 8'h30;
                            oct_count = 2'd1;
                            scan_ph   = PH_OCT;
                        end else begin
                            put_result(K_SBYTE, b, 32'd0, 1'b0);
                        end
                    end
                endcase
            end
            PH_OCT: begin
                if (is_decimal(b)) begin
                    // 8 and 9 count as digits too; the value wraps to a byte
                    oct_acc   = {oct_acc[4:0], 3'b000} + (b - 8'h30);
                    oct_count = oct_count + 2'd1;
                    if (oct_count == 2'd3) begin
                        put_result(K_SBYTE, oct_acc, 32'd0, 1'b0);
                        scan_ph = PH_STR;
                    end
                end else begin
                    put_result(K_SBYTE, oct_acc, 32'd0, 1'b0);
                    scan_ph = PH_STR;
                    string_char(b);
                end
            end
            default: scan_ph = PH_SEEK;
        endcase
    endtask

    // End of the text closes whatever query is still open.
    task automatic end_of_text();
        if (!answered) begin
            case (scan_ph)
                PH_NUM_WS, PH_NUM_DIG: report_number();
                PH_OCT: begin
                    put_result(K_SBYTE, oct_acc, 32'd0, 1'b0);
                    close_query(K_SEND, 32'd0);
                end
                PH_STR, PH_CARET, PH_ESC: close_query(K_SEND, 32'd0);
                default: close_query(K_NONE, 32'd0);
            endcase
        end
    endtask

    task automatic clear_scan();
        scan_ph   = PH_SEEK;
        oct_acc   = 8'd0;
        oct_count = 2'd0;
        num_mag   = 32'd0;
        num_neg   = 1'b0;
        answered  = 1'b0;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        step_results = 0;
        if (!answered) begin
            if (b == CH_NUL) end_of_text();
            else advance_scan(b);
        end
        if (last) begin
            end_of_text();
            clear_scan();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            want_name = 16'd0;
            want_kind = QK_NUM;
            clear_scan();
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_CAP_NAME) want_name = i_cfg_data;
                else want_kind = i_cfg_data[1:0];
            end
            if (i_in_valid && !i_in_stall)
                take_byte(i_in_data.entry_byte, i_in_data.entry_end);
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: result_kind %0d string_byte 'h%02h number_value %0d",
                           i_out_data.result_kind, i_out_data.string_byte,
                           i_out_data.number_value);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.result_kind != want.result_kind) begin
                        $error("result_kind: expected %0d, actual %0d",
                               want.result_kind, i_out_data.result_kind);
                        errors++;
                    end
                    if (i_out_data.string_byte != want.string_byte) begin
                        $error("string_byte: expected 'h%02h, actual 'h%02h",
                               want.string_byte, i_out_data.string_byte);
                        errors++;
                    end
                    if (i_out_data.number_value != want.number_value) begin
                        $error("number_value: expected %0d, actual %0d",
                               want.number_value, i_out_data.number_value);
                        errors++;
                    end
                    if (i_out_data.final_result != want.final_result) begin
                        $error("final_result: expected %0d, actual %0d",
                               want.final_result, i_out_data.final_result);
                        errors++;
                    end
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= errors;
    end

endmodule

>>> tb/tb.sv
// Top of the capability entry lookup testbench: clock, reset, entry stimulus and verdict.
// Depends on cel_pkg, capability_entry_lookup and capability_lookup_checker.
`timescale 1ns / 1ps

module tb;
    import cel_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    int          fail_count;
    int          pending_count;
    bit          idle_on;
    int          bytes_sent = 0;
    logic [15:0] cur_name;
    logic [1:0]  cur_kind;
    logic [7:0]  entry_q[$];

    capability_entry_lookup dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    capability_lookup_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop: a run still going at the time limit fails.
    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result-side backpressure: random stall bursts while idling is on.
    initial begin : result_stall
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) hold--;
            else if (idle_on && $urandom_range(0, 6) == 0) hold = $urandom_range(1, 14);
            out_stall <= (hold > 0);
        end
    end

    // Offer one entry byte and hold it until the block takes it. While idling is on,
    // sometimes insert a random gap first so that pauses land on every scan phase.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.entry_byte <= b;
        in_data.entry_end  <= last;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // Send the assembled entry, flagging its final byte as the end of the text.
    task automatic send_entry();
        foreach (entry_q[i]) send_byte(entry_q[i], i == entry_q.size() - 1);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) entry_q.push_back(s[i]);
    endtask

    task automatic send_line(input string s);
        entry_q.delete();
        add_text(s);
        send_entry();
    endtask

    // Drop valid and wait for every predicted result, then keep waiting since the last
    // byte of an entry may still be in flight without causing a result.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Change the lookup only with the block idle. Fill the unused upper bits of the
    // query kind write with noise.
    task automatic set_lookup(input logic [15:0] name, input logic [1:0] kind);
        drain();
        cur_name = name;
        cur_kind = kind;
        write_reg(CFG_CAP_NAME, name);
        write_reg(CFG_QUERY_KIND, {14'($urandom_range(0, 16383)), kind});
    endtask

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
    endfunction

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic add_number();
        int r;
        repeat ($urandom_range(0, 1)) entry_q.push_back(blank_char());
        r = $urandom_range(0, 2);
        if (r == 1) entry_q.push_back(CH_PLUS);
        else if (r == 2) entry_q.push_back(CH_MINUS);
        // long runs push the magnitude into saturation
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 4);
        repeat (r) entry_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
        r = $urandom_range(0, 2);
        if (r == 1) entry_q.push_back(CH_COLON);
        else if (r == 2) entry_q.push_back(8'($urandom_range(33, 126)));
    endtask

    task automatic add_string();
        int r;
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 5);
            case (r)
                1: begin
                    entry_q.push_back(CH_CARET);
                    entry_q.push_back(8'($urandom_range(32, 126)));
                end
                2: begin
                    entry_q.push_back(CH_BSL);
                    entry_q.push_back(pick("EnrtbfX8\\^:"));
                end
                3: begin
                    entry_q.push_back(CH_BSL);
                    entry_q.push_back(8'h30 + 8'($urandom_range(0, 3)));
                    repeat ($urandom_range(0, 3)) entry_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
                end
                4: entry_q.push_back(8'($urandom_range(1, 255)));
                default: entry_q.push_back(8'($urandom_range(32, 126)));
            endcase
        end
        // close with a separator, a dangling escape prefix, or just the end of the text
        r = $urandom_range(0, 3);
        if (r == 0) entry_q.push_back(CH_COLON);
        else if (r == 1) entry_q.push_back(CH_BSL);
        else if (r == 2) entry_q.push_back(CH_CARET);
    endtask

    // Build one random entry for the current lookup. Most entries carry a well-formed
    // target field behind unrelated fields; the rest are near misses or raw noise.
    task automatic build_entry();
        int style;
        entry_q.delete();
        repeat ($urandom_range(0, 2)) begin
            entry_q.push_back(CH_COLON);
            repeat ($urandom_range(1, 3)) entry_q.push_back(8'($urandom_range(33, 126)));
        end
        style = $urandom_range(0, 9);
        if (style == 0) begin
            repeat ($urandom_range(2, 10)) entry_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            entry_q.push_back(CH_COLON);
            repeat ($urandom_range(0, 2)) entry_q.push_back(blank_char());
            entry_q.push_back(cur_name[15:8]);
            if (style == 1) entry_q.push_back(8'($urandom_range(33, 126)));
            else entry_q.push_back(cur_name[7:0]);
            if (style == 2) entry_q.push_back(pick("#=:"));
            else if (cur_kind == QK_NUM) entry_q.push_back(CH_HASH);
            else if (cur_kind == QK_STR) entry_q.push_back(CH_EQ);
            case (cur_kind)
                QK_NUM: add_number();
                QK_STR: add_string();
                default: repeat ($urandom_range(0, 3)) entry_q.push_back(8'($urandom_range(32, 126)));
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            entry_q.push_back(CH_COLON);
            repeat ($urandom_range(1, 4)) entry_q.push_back(8'($urandom_range(0, 255)));
        end
        // occasionally cut the text short with a zero byte
        if ($urandom_range(0, 9) == 0)
            entry_q.insert($urandom_range(0, entry_q.size() - 1), CH_NUL);
    endtask

    initial begin : stimulus
        int rand_entries;
        int start_bytes;
        int r;
        logic [15:0] name;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CAP_NAME;
        cfg_data  <= 16'd0;
        idle_on   <= 1'b1;
        cur_name  = 16'd0;
        cur_kind  = QK_NUM;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings (name of two zero bytes): a zero byte ends the text and never
        // matches the name, and the bytes after it are ignored up to the end flag.
        entry_q.delete();
        entry_q.push_back(CH_COLON);
        entry_q.push_back(CH_NUL);
        entry_q.push_back(8'hFF);
        send_entry();

        // Number queries: both saturation limits, whitespace and sign, a byte that
        // breaks the name and opens the next field, bytes after the answer.
        set_lookup("co", QK_NUM);
        send_line(":c:co#-3000000000");
        send_line(": co# +99999999999:");
        send_line(":co#5 co#6");

        // Flag query, then an entry without the name.
        set_lookup("am", QK_FLAG);
        send_line(":a:am");
        send_line(":zz");

        // String query: caret, named escapes, octal with 9 as a digit, a plain
        // escaped byte, and escape prefixes or a pending octal at the end.
        set_lookup("st", QK_STR);
        send_line(":st=^A\\E\\n\\r\\t\\b\\f\\19q\\1234\\8^?:");
        send_line(":st=a\\");
        send_line(":st=\\3");
        send_line(":st=^");

        // Undefined query kind never matches.
        set_lookup("co", QK_NEVER);
        send_line(":co#1");

        // All-ones name.
        set_lookup(16'hFFFF, QK_FLAG);
        entry_q.delete();
        entry_q.push_back(CH_COLON);
        entry_q.push_back(8'hFF);
        entry_q.push_back(8'hFF);
        entry_q.push_back(8'h78);
        send_entry();

        // Random part: a new lookup every other entry, calm after the first entry.
        start_bytes  = bytes_sent;
        rand_entries = 0;
        while (bytes_sent - start_bytes < 16) begin
            if (rand_entries % 2 == 0) begin
                r = $urandom_range(0, 9);
                if (r == 0) name = 16'h0000;
                else if (r == 1) name = 16'hFFFF;
                else if (r == 2) name = 16'($urandom_range(0, 65535));
                else name = {pick("abco"), pick("abco")};
                set_lookup(name, 2'($urandom_range(0, 2)));
            end
            idle_on <= (rand_entries >= 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            build_entry();
            send_entry();
            rand_entries++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/cel_pkg.sv
rtl/cel_scanner.sv
rtl/capability_entry_lookup.sv
rtl/cel_checker.sv
tb/capability_lookup_checker.sv
tb/tb.sv
